// ----- rtl/core/mcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpf_pkg
// Shared types, codes and byte tables for the MQTT control packet framer.
// ----------------------------------------------------------------------------
package mcpf_pkg;

    localparam int MAX_RL_DEFAULT      = 127;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam logic [15:0] KEEP_ALIVE_RESET = 16'd60;

    typedef struct packed {
        logic       cmd;
        logic [2:0] packet_kind;
        logic [6:0] first_length;
        logic [6:0] second_length;
        logic [7:0] payload_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       packet_end;
        logic       error;
    } result_t;

    // item command codes
    localparam logic CMD_BEGIN   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // packet kinds
    localparam logic [2:0] KIND_CONNECT     = 3'd0;
    localparam logic [2:0] KIND_PUBLISH     = 3'd1;
    localparam logic [2:0] KIND_SUBSCRIBE   = 3'd2;
    localparam logic [2:0] KIND_UNSUBSCRIBE = 3'd3;
    localparam logic [2:0] KIND_PINGREQ     = 3'd4;
    localparam logic [2:0] KIND_DISCONNECT  = 3'd5;

    // work codes passed from front to back
    localparam logic [1:0] JOB_HEADER  = 2'd0;
    localparam logic [1:0] JOB_PAYLOAD = 2'd1;
    localparam logic [1:0] JOB_ERROR   = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] kind;
        logic [6:0] rem_len;
        logic [6:0] id_len;
        logic [7:0] data;
        logic       pend;   // packet ends on the last non-QoS byte
        logic       qos;    // append requested-QoS byte, which ends the packet
    } job_t;

    // fixed header first bytes
    localparam logic [7:0] FH_CONNECT     = 8'd16;
    localparam logic [7:0] FH_PUBLISH     = 8'd48;
    localparam logic [7:0] FH_SUBSCRIBE   = 8'h82;
    localparam logic [7:0] FH_UNSUBSCRIBE = 8'hA2;
    localparam logic [7:0] FH_PINGREQ     = 8'd192;
    localparam logic [7:0] FH_DISCONNECT  = 8'd224;

    // "MQIsdp", level 3
    localparam logic [7:0] PROTO_NAME_LEN = 8'd6;
    localparam logic [7:0] CH_M  = 8'd77;
    localparam logic [7:0] CH_Q  = 8'd81;
    localparam logic [7:0] CH_I  = 8'd73;
    localparam logic [7:0] CH_S  = 8'd115;
    localparam logic [7:0] CH_D  = 8'd100;
    localparam logic [7:0] CH_P  = 8'd112;
    localparam logic [7:0] PROTO_LEVEL = 8'd3;

    // header byte count per kind
    function automatic logic [4:0] header_len(input logic [2:0] kind);
        logic [4:0] len;
        case (kind)
            KIND_CONNECT:                     len = 5'd16;
            KIND_PUBLISH:                     len = 5'd4;
            KIND_SUBSCRIBE, KIND_UNSUBSCRIBE: len = 5'd6;
            default:                          len = 5'd2;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] header_byte(
        input logic [2:0]  kind,
        input logic [3:0]  idx,
        input logic [6:0]  rl,
        input logic [6:0]  l1,
        input logic [15:0] ka
    );
        logic [7:0] b;
        b = 8'd0;
        case (kind)
            KIND_CONNECT: begin
                case (idx)
                    4'd0:    b = FH_CONNECT;
                    4'd1:    b = {1'b0, rl};
                    4'd3:    b = PROTO_NAME_LEN;
                    4'd4:    b = CH_M;
                    4'd5:    b = CH_Q;
                    4'd6:    b = CH_I;
                    4'd7:    b = CH_S;
                    4'd8:    b = CH_D;
                    4'd9:    b = CH_P;
                    4'd10:   b = PROTO_LEVEL;
                    4'd12:   b = ka[15:8];
                    4'd13:   b = ka[7:0];
                    4'd15:   b = {1'b0, l1};
                    default: b = 8'd0;
                endcase
            end
            KIND_PUBLISH: begin
                case (idx)
                    4'd0:    b = FH_PUBLISH;
                    4'd1:    b = {1'b0, rl};
                    4'd3:    b = {1'b0, l1};
                    default: b = 8'd0;
                endcase
            end
            KIND_SUBSCRIBE, KIND_UNSUBSCRIBE: begin
                case (idx)
                    4'd0:    b = (kind == KIND_SUBSCRIBE) ? FH_SUBSCRIBE : FH_UNSUBSCRIBE;
                    4'd1:    b = {1'b0, rl};
                    4'd5:    b = {1'b0, l1};
                    default: b = 8'd0;
                endcase
            end
            default: begin
                case (idx)
                    4'd0:    b = (kind == KIND_PINGREQ) ? FH_PINGREQ : FH_DISCONNECT;
                    default: b = 8'd0;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/mcpf_front.sv -----
// ----------------------------------------------------------------------------
// mcpf_front
// Accepts items, tracks the packet in progress and queues one job per item.
// ----------------------------------------------------------------------------
module mcpf_front #(
    parameter int MAX_REMAINING_LENGTH = mcpf_pkg::MAX_RL_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  mcpf_pkg::item_t item,
    output logic            job_valid,
    input  logic            job_ready,
    output mcpf_pkg::job_t  job
);

    localparam logic [8:0] RL_LIMIT = 9'(MAX_REMAINING_LENGTH);

    logic [7:0] payload_left_reg, payload_left_next;
    logic [2:0] held_kind_reg, held_kind_next;
    logic [8:0] rl_wide;
    logic [7:0] pay;
    logic       kind_bad;
    logic       accept;

    assign item_ready = job_ready;
    assign job_valid  = item_valid;
    assign accept     = item_valid && job_ready;

    always_comb
    begin
        kind_bad = 1'b0;
        case (item.packet_kind)
            mcpf_pkg::KIND_CONNECT: begin
                rl_wide = 9'd14 + {2'b00, item.first_length};
                pay     = {1'b0, item.first_length};
            end
            mcpf_pkg::KIND_PUBLISH: begin
                rl_wide = 9'd2 + {2'b00, item.first_length} + {2'b00, item.second_length};
                pay     = {1'b0, item.first_length} + {1'b0, item.second_length};
            end
            mcpf_pkg::KIND_SUBSCRIBE: begin
                rl_wide = 9'd5 + {2'b00, item.first_length};
                pay     = {1'b0, item.first_length};
            end
            mcpf_pkg::KIND_UNSUBSCRIBE: begin
                rl_wide = 9'd4 + {2'b00, item.first_length};
                pay     = {1'b0, item.first_length};
            end
            mcpf_pkg::KIND_PINGREQ, mcpf_pkg::KIND_DISCONNECT: begin
                rl_wide = 9'd0;
                pay     = 8'd0;
            end
            default: begin
                rl_wide  = 9'd0;
                pay      = 8'd0;
                kind_bad = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        payload_left_next = payload_left_reg;
        held_kind_next    = held_kind_reg;
        job.op      = mcpf_pkg::JOB_ERROR;
        job.kind    = item.packet_kind;
        job.rem_len = rl_wide[6:0];
        job.id_len  = item.first_length;
        job.data    = item.payload_byte;
        job.pend    = 1'b0;
        job.qos     = 1'b0;
        if (item.cmd == mcpf_pkg::CMD_BEGIN) begin
            if (kind_bad || rl_wide > RL_LIMIT) begin
                payload_left_next = 8'd0;
            end
            else begin
                job.op            = mcpf_pkg::JOB_HEADER;
                held_kind_next    = item.packet_kind;
                payload_left_next = pay;
                job.pend = (pay == 8'd0) && (item.packet_kind != mcpf_pkg::KIND_SUBSCRIBE);
                job.qos  = (pay == 8'd0) && (item.packet_kind == mcpf_pkg::KIND_SUBSCRIBE);
            end
        end
        else if (payload_left_reg != 8'd0) begin
            job.op            = mcpf_pkg::JOB_PAYLOAD;
            payload_left_next = payload_left_reg - 8'd1;
            job.pend = (payload_left_reg == 8'd1) && (held_kind_reg != mcpf_pkg::KIND_SUBSCRIBE);
            job.qos  = (payload_left_reg == 8'd1) && (held_kind_reg == mcpf_pkg::KIND_SUBSCRIBE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            payload_left_reg <= 8'd0;
            held_kind_reg    <= mcpf_pkg::KIND_CONNECT;
        end
        else if (accept) begin
            payload_left_reg <= payload_left_next;
            held_kind_reg    <= held_kind_next;
        end
    end

endmodule

// ----- rtl/core/mcpf_queue.sv -----
// ----------------------------------------------------------------------------
// mcpf_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mcpf_queue #(
    parameter int DEPTH = mcpf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mcpf_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop,
    output mcpf_pkg::job_t pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    mcpf_pkg::job_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow push");

endmodule

// ----- rtl/core/mcpf_back.sv -----
// ----------------------------------------------------------------------------
// mcpf_back
// Expands queued jobs into result bytes in a register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module mcpf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  mcpf_pkg::job_t    job,
    output logic              job_pop,
    input  logic [15:0]       keep_alive,
    output logic              result_valid,
    input  logic              result_ready,
    output mcpf_pkg::result_t result
);

    logic [3:0]        idx_reg, idx_next;
    logic              result_valid_reg;
    mcpf_pkg::result_t result_reg, res_next;
    logic [4:0]        idx5, base, total;
    logic              advance, emit, last_byte;

    assign idx5    = {1'b0, idx_reg};
    assign advance = !result_valid_reg || result_ready;
    assign emit    = advance && job_valid;

    always_comb
    begin
        base  = (job.op == mcpf_pkg::JOB_HEADER) ? mcpf_pkg::header_len(job.kind) : 5'd1;
        total = (job.op == mcpf_pkg::JOB_ERROR) ? 5'd1 : base + {4'd0, job.qos};
        last_byte = (idx5 == total - 5'd1);

        res_next.run_end    = last_byte;
        res_next.error      = 1'b0;
        res_next.out_byte   = 8'd0;
        res_next.packet_end = 1'b0;
        if (job.op == mcpf_pkg::JOB_ERROR) begin
            res_next.error = 1'b1;
        end
        else begin
            if (idx5 < base) begin
                res_next.out_byte = (job.op == mcpf_pkg::JOB_HEADER)
                    ? mcpf_pkg::header_byte(job.kind, idx_reg, job.rem_len, job.id_len,
                                            keep_alive)
                    : job.data;
            end
            // last regular byte carries the job's end flag; the QoS byte always ends
            if (idx5 == base - 5'd1) begin
                res_next.packet_end = job.pend;
            end
            else if (idx5 == base) begin
                res_next.packet_end = 1'b1;
            end
        end
        idx_next = last_byte ? 4'd0 : idx_reg + 4'd1;
    end

    assign job_pop      = emit && last_byte;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg          <= 4'd0;
            result_valid_reg <= 1'b0;
        end
        else begin
            if (emit) begin
                idx_reg          <= idx_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            result_reg <= res_next;
        end
    end

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.error) |->
            (result_reg.out_byte == 8'd0 && !result_reg.packet_end && result_reg.run_end))
        else $error("malformed error result");

    a_pend_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.packet_end) |-> result_reg.run_end)
        else $error("packet end without run end");

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> idx5 < total)
        else $error("byte index past end of job");

endmodule

// ----- rtl/core/mqtt_control_packet_framer.sv -----
// ----------------------------------------------------------------------------
// mqtt_control_packet_framer
// MQTT 3.1 control packet encoder producing a byte stream.
// ----------------------------------------------------------------------------
// Channels: item (valid/ready, item_t) takes begin requests (cmd 0: packet kind
// and string lengths) and payload requests (cmd 1: one byte). result
// (valid/ready, result_t) gives the packet bytes; run_end marks the last byte
// caused by a request, packet_end the last byte of the packet, error a refused
// request (out_byte zero). cfg (valid/ready, 16-bit data) sets the keep-alive
// time; it is always ready. The user must write it only while the block is
// idle; the block does not enforce this. Requests go via the job queue to the
// result register. Throughput: one result byte per cycle unless result_ready
// stalls, set by the single byte expander in the back part; a payload request
// gives one byte (two for the last subscribe topic byte), a header 2 to 16
// bytes. A job queue (four entries by default) decouples acceptance from byte
// generation, so items keep being taken while a header burst is still draining
// or the receiver stalls; item_ready drops only when the queue is full.
// Reset: no packet in progress, keep-alive 60, queue and result register empty.
// ----------------------------------------------------------------------------
module mqtt_control_packet_framer #(
    parameter int MAX_REMAINING_LENGTH = mcpf_pkg::MAX_RL_DEFAULT,
    parameter int QUEUE_DEPTH          = mcpf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mcpf_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output mcpf_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    logic [15:0]    keep_alive_reg;
    logic           f_valid, f_ready, q_valid, q_pop;
    mcpf_pkg::job_t f_job, q_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            keep_alive_reg <= mcpf_pkg::KEEP_ALIVE_RESET;
        end
        else if (cfg_valid) begin
            keep_alive_reg <= cfg_data;
        end
    end

    mcpf_front #(
        .MAX_REMAINING_LENGTH (MAX_REMAINING_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    mcpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_job    (q_job)
    );

    mcpf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_valid),
        .job          (q_job),
        .job_pop      (q_pop),
        .keep_alive   (keep_alive_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
